[hw/rtl/bbrc_pkg.sv]
// Shared types, constants and helpers for the band to FFT bin range calculator.
// Used by every module under hw/rtl; depends on nothing.
package bbrc_pkg;

  localparam int unsigned MAX_LOG2   = 16;
  localparam int unsigned MIN_LOG2   = 3;
  localparam int unsigned BIN_W      = MAX_LOG2;
  localparam int unsigned LG_W       = 5;
  localparam int unsigned SPAN_W     = 21;
  localparam int unsigned POS_W      = 26;
  localparam int unsigned EDGE_W     = 29;
  localparam int unsigned DIV_W      = SPAN_W + 1;
  localparam int unsigned FREQ_W     = 27;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = MAX_LOG2 / DIV_STEPS;

  localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(1000000);
  localparam logic [LG_W-1:0]   LG_RST   = LG_W'(11);

  typedef enum logic [1:0] {
    REG_CAPTURE_SPAN = 2'd0,
    REG_FILTER_SPAN  = 2'd1,
    REG_FFT_LOG2     = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    STAT_OUT = 2'd0,
    STAT_ONE = 2'd1,
    STAT_TWO = 2'd2
  } status_e;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] filt;
    logic [LG_W-1:0]   lg;
  } cfg_t;

  typedef struct packed {
    logic                     ok;
    logic                     top_r;
    logic signed [EDGE_W-1:0] cl2;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [BIN_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    side_t side;
    lane_t lo;
    lane_t hi;
  } div_t;

  typedef struct packed {
    status_e                  status;
    logic signed [FREQ_W-1:0] freq_low;
    logic signed [FREQ_W-1:0] freq_high;
    logic [BIN_W-1:0]         first_low_bin;
    logic [BIN_W-1:0]         first_high_bin;
    logic [BIN_W-1:0]         second_low_bin;
    logic [BIN_W-1:0]         second_high_bin;
  } res_t;

  // one restoring division step: remainder doubles, quotient gains one bit
  function automatic lane_t div_step(lane_t x, logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] s;
    lane_t          y;
    t = {x.rem, 1'b0};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      y.rem = s[DIV_W-1:0];
      y.quo = {x.quo[BIN_W-2:0], 1'b1};
    end else begin
      y.rem = t[DIV_W-1:0];
      y.quo = {x.quo[BIN_W-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [LG_W-1:0] clamp_lg(logic [LG_W-1:0] v);
    logic [LG_W-1:0] r;
    r = v;
    if (v < LG_W'(MIN_LOG2)) r = LG_W'(MIN_LOG2);
    if (v > LG_W'(MAX_LOG2)) r = LG_W'(MAX_LOG2);
    return r;
  endfunction

endpackage

[hw/rtl/fft_band_bin_range_calc_top.sv]
// Top level of the band to FFT bin range calculator: config registers and pipeline.
// Depends on bbrc_pkg, bbrc_check, bbrc_div and bbrc_edge.
//
// Input stream (s_axis): one item per band query, capture centre, band centre and
// band width in 100 Hz units. Output stream (m_axis): one item per input item,
// carrying status, covered frequency edges and up to two fftshifted bin ranges.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i (0 capture span,
// 1 filter span, 2 FFT log2); other indexes are dropped. Write only while idle.
// The pipeline is one range check stage, eight divider stages of two
// restoring steps each, and four stages for bins, products, rounding and saturation.
// One item per cycle unless the receiver stalls; every stage has its own valid bit.
// When the receiver stalls, stages fill up from the output end, so items keep
// being accepted until the pipeline holds no bubble; nothing is lost or repeated.
// Reset empties the pipeline and loads span 1000000, filter span 1000000 and
// FFT log2 11.
module fft_band_bin_range_calc_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [20:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [25:0] capture_center, [51:26] band_center, [72:52] band_width, rest zero
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [28:2] freq_low, [55:29] freq_high, [71:56] first_low_bin,
  // [87:72] first_high_bin, [103:88] second_low_bin, [119:104] second_high_bin
  output logic [119:0] m_axis_tdata
);

  bbrc_pkg::cfg_t  cfg_q;
  logic            chk_vld, chk_rdy, div_vld, div_rdy;
  bbrc_pkg::div_t  chk_data, div_data;
  bbrc_pkg::res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.span <= bbrc_pkg::SPAN_RST;
      cfg_q.filt <= bbrc_pkg::SPAN_RST;
      cfg_q.lg   <= bbrc_pkg::LG_RST;
    end else if (cfg_we_i) begin
      unique case (bbrc_pkg::reg_idx_e'(cfg_addr_i))
        bbrc_pkg::REG_CAPTURE_SPAN: cfg_q.span <= cfg_wdata_i;
        bbrc_pkg::REG_FILTER_SPAN:  cfg_q.filt <= cfg_wdata_i;
        bbrc_pkg::REG_FFT_LOG2:     cfg_q.lg   <= bbrc_pkg::clamp_lg(cfg_wdata_i[4:0]);
        default: ;
      endcase
    end
  end

  bbrc_check u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .capture_center_i(s_axis_tdata[25:0]),
    .band_center_i   (s_axis_tdata[51:26]),
    .band_width_i    (s_axis_tdata[72:52]),
    .out_valid_o     (chk_vld),
    .out_ready_i     (chk_rdy),
    .out_data_o      (chk_data)
  );

  bbrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .span_i     (cfg_q.span),
    .in_valid_i (chk_vld),
    .in_ready_o (chk_rdy),
    .in_data_i  (chk_data),
    .out_valid_o(div_vld),
    .out_ready_i(div_rdy),
    .out_data_o (div_data)
  );

  bbrc_edge u_edge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (div_vld),
    .in_ready_o (div_rdy),
    .in_data_i  (div_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (res)
  );

  assign m_axis_tdata = {res.second_high_bin, res.second_low_bin, res.first_high_bin,
                         res.first_low_bin, res.freq_high, res.freq_low, res.status};

  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == bbrc_pkg::STAT_OUT |->
      res.freq_low == '0 && res.freq_high == '0 && res.first_low_bin == '0 &&
      res.first_high_bin == '0 && res.second_low_bin == '0 && res.second_high_bin == '0)
    else $error("rejected item carries nonzero fields");

  a_one_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == bbrc_pkg::STAT_ONE |->
      res.second_low_bin == '0 && res.second_high_bin == '0 &&
      res.first_low_bin <= res.first_high_bin)
    else $error("single range malformed");

  a_two_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == bbrc_pkg::STAT_TWO |->
      res.first_low_bin == '0 && res.second_low_bin > res.first_high_bin)
    else $error("split range malformed");

  // narrow bins round both edges to the same unit, so only order is checked
  a_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status != bbrc_pkg::STAT_OUT |-> res.freq_low <= res.freq_high)
    else $error("covered edges out of order");

endmodule

[hw/rtl/bbrc_check.sv]
// Range check stage: band edges against filter and capture spans, divider operands.
// Depends on bbrc_pkg.
module bbrc_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbrc_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bbrc_pkg::POS_W-1:0]    capture_center_i,
  input  logic [bbrc_pkg::POS_W-1:0]    band_center_i,
  input  logic [bbrc_pkg::SPAN_W-1:0]   band_width_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bbrc_pkg::div_t                out_data_o
);

  localparam int unsigned EW = bbrc_pkg::EDGE_W;

  logic signed [EW-1:0] cc2, bc2, s_x, f_x, w_x;
  logic signed [EW-1:0] cl2, cr2, fl2, fr2, bl2, br2, al, ar;
  logic                 ok;
  logic                 en;
  logic                 vld_q;
  bbrc_pkg::div_t       data_d, data_q;

  always_comb begin
    cc2 = $signed({2'b00, capture_center_i, 1'b0});
    bc2 = $signed({2'b00, band_center_i, 1'b0});
    s_x = $signed({8'b0, cfg_i.span});
    f_x = $signed({8'b0, cfg_i.filt});
    w_x = $signed({8'b0, band_width_i});
    cl2 = cc2 - s_x;
    cr2 = cc2 + s_x;
    fl2 = cc2 - f_x;
    fr2 = cc2 + f_x;
    bl2 = bc2 - w_x;
    br2 = bc2 + w_x;
    al  = bl2 - cl2;
    ar  = br2 - cl2;
    ok  = (cfg_i.span != '0) && (band_width_i != '0) && (bl2 >= fl2) && (br2 <= fr2)
          && (bl2 >= cl2) && (br2 <= cr2);

    data_d.side.ok    = ok;
    data_d.side.top_r = (br2 == cr2);
    data_d.side.cl2   = cl2;
    data_d.lo.rem     = al[bbrc_pkg::DIV_W-1:0];
    data_d.lo.quo     = '0;
    // right edge on the capture edge is handled apart, keep the divider below d
    data_d.hi.rem     = (br2 == cr2) ? '0 : ar[bbrc_pkg::DIV_W-1:0];
    data_d.hi.quo     = '0;
  end

  assign en         = !vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

[hw/rtl/bbrc_div.sv]
// Pipelined restoring divider, two lanes sharing the divisor 2*capture_span.
// Depends on bbrc_pkg (div_step, DIV_STAGES, DIV_STEPS).
module bbrc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bbrc_pkg::SPAN_W-1:0] span_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bbrc_pkg::div_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bbrc_pkg::div_t              out_data_o
);

  localparam int unsigned NS = bbrc_pkg::DIV_STAGES;

  logic [bbrc_pkg::DIV_W-1:0] d;
  logic [NS-1:0]              vld_q;
  logic [NS-1:0]              en;
  bbrc_pkg::div_t             stg_d [NS];
  bbrc_pkg::div_t             stg_q [NS];

  assign d = {span_i, 1'b0};

  always_comb begin
    bbrc_pkg::div_t cur;
    cur = in_data_i;
    for (int k = 0; k < NS; k++) begin
      for (int j = 0; j < bbrc_pkg::DIV_STEPS; j++) begin
        cur.lo = bbrc_pkg::div_step(cur.lo, d);
        cur.hi = bbrc_pkg::div_step(cur.hi, d);
      end
      stg_d[k] = cur;
      cur      = stg_q[k];
    end
  end

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) stg_q[k] <= stg_d[k];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_data_o  = stg_q[NS-1];

endmodule

[hw/rtl/bbrc_edge.sv]
// Bin numbers, fftshift mapping and covered frequency edges, four stages.
// Depends on bbrc_pkg; fed by bbrc_div.
module bbrc_edge (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bbrc_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bbrc_pkg::div_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bbrc_pkg::res_t out_data_o
);

  localparam int unsigned BW = bbrc_pkg::BIN_W;
  localparam int unsigned EW = bbrc_pkg::EDGE_W;
  localparam int unsigned PW = BW + 1 + bbrc_pkg::SPAN_W;
  localparam int unsigned YW = PW + 2;
  localparam int unsigned VW = PW - 1;
  localparam int unsigned SW = VW + 2;
  localparam int unsigned FW = bbrc_pkg::FREQ_W;

  typedef struct packed {
    logic                 ok;
    logic signed [EW-1:0] cl2;
    logic [BW-1:0]        lb;
    logic [BW-1:0]        rb;
    logic [BW:0]          rb1;
  } e1_t;

  typedef struct packed {
    logic                 ok;
    logic signed [EW-1:0] cl2;
    logic [PW-1:0]        pl;
    logic [PW-1:0]        ph;
    bbrc_pkg::status_e    status;
    logic [BW-1:0]        b0, b1, b2, b3;
  } e2_t;

  typedef struct packed {
    logic                 ok;
    logic signed [EW-2:0] h;
    logic [VW-1:0]        vl;
    logic [VW-1:0]        vh;
    bbrc_pkg::status_e    status;
    logic [BW-1:0]        b0, b1, b2, b3;
  } e3_t;

  logic [bbrc_pkg::LG_W-1:0] lg, k;
  logic [3:0]                vld_q, en;
  e1_t                       s1_d, s1_q;
  e2_t                       s2_d, s2_q;
  e3_t                       s3_d, s3_q;
  bbrc_pkg::res_t            s4_d, s4_q;

  assign lg = cfg_i.lg;
  assign k  = bbrc_pkg::LG_W'(bbrc_pkg::MAX_LOG2) - lg;

  // stage 1: scale quotients down to the FFT size, ceiling for the right edge
  always_comb begin
    logic [BW-1:0] low_mask;
    logic          inexact;
    logic [BW:0]   n;
    low_mask = ~({BW{1'b1}} << k);
    inexact  = (in_data_i.hi.rem != '0) || ((in_data_i.hi.quo & low_mask) != '0);
    n        = (BW+1)'(1) << lg;
    s1_d.ok  = in_data_i.side.ok;
    s1_d.cl2 = in_data_i.side.cl2;
    s1_d.lb  = in_data_i.lo.quo >> k;
    s1_d.rb1 = in_data_i.side.top_r ? n
             : ({1'b0, in_data_i.hi.quo >> k} + (BW+1)'(inexact));
    s1_d.rb  = BW'(s1_d.rb1 - (BW+1)'(1));
  end

  // stage 2: edge products and half exchange
  always_comb begin
    logic [BW-1:0] half, nm1, l, r;
    logic          l_lo, r_lo;
    half = BW'((BW+1)'(1) << (lg - bbrc_pkg::LG_W'(1)));
    nm1  = BW'(((BW+1)'(1) << lg) - (BW+1)'(1));
    l    = s1_q.lb ^ half;
    r    = s1_q.rb ^ half;
    l_lo = l < half;
    r_lo = r < half;
    s2_d.ok  = s1_q.ok;
    s2_d.cl2 = s1_q.cl2;
    s2_d.pl  = PW'(s1_q.lb) * PW'(cfg_i.span);
    s2_d.ph  = PW'(s1_q.rb1) * PW'(cfg_i.span);
    s2_d.b2  = '0;
    s2_d.b3  = '0;
    if (l_lo == r_lo) begin
      s2_d.status = bbrc_pkg::STAT_ONE;
      s2_d.b0     = l;
      s2_d.b1     = r;
    end else if (l == half && r == half - BW'(1)) begin
      s2_d.status = bbrc_pkg::STAT_ONE;
      s2_d.b0     = '0;
      s2_d.b1     = nm1;
    end else begin
      s2_d.status = bbrc_pkg::STAT_TWO;
      s2_d.b0     = '0;
      s2_d.b1     = r;
      s2_d.b2     = l;
      s2_d.b3     = nm1;
    end
  end

  // stage 3: round to nearest by adding half a step, then shift out the FFT size
  always_comb begin
    logic [YW-1:0] rnd, yl, yh;
    logic [YW-1:0] odd;
    rnd = YW'(1) << lg;
    odd = YW'(s2_q.cl2[0]) << lg;
    yl  = {1'b0, s2_q.pl, 1'b0} + rnd + odd;
    yh  = {1'b0, s2_q.ph, 1'b0} + rnd + odd;
    s3_d.ok     = s2_q.ok;
    s3_d.h      = s2_q.cl2[EW-1:1];
    s3_d.vl     = VW'(yl >> (lg + bbrc_pkg::LG_W'(1)));
    s3_d.vh     = VW'(yh >> (lg + bbrc_pkg::LG_W'(1)));
    s3_d.status = s2_q.status;
    s3_d.b0     = s2_q.b0;
    s3_d.b1     = s2_q.b1;
    s3_d.b2     = s2_q.b2;
    s3_d.b3     = s2_q.b3;
  end

  function automatic logic [FW-1:0] sat_freq(logic [SW-1:0] v);
    logic hi, lo;
    hi = !v[SW-1] && (v[SW-2:FW-1] != '0);
    lo = v[SW-1] && (v[SW-2:FW-1] != '1);
    if (hi)      return {1'b0, {(FW-1){1'b1}}};
    else if (lo) return {1'b1, {(FW-1){1'b0}}};
    else         return v[FW-1:0];
  endfunction

  // stage 4: add the capture left edge, saturate, clear rejected items
  always_comb begin
    logic [SW-1:0] hx, sl, sh;
    hx = {{(SW-EW+1){s3_q.h[EW-2]}}, s3_q.h};
    sl = hx + {2'b00, s3_q.vl};
    sh = hx + {2'b00, s3_q.vh};
    if (s3_q.ok) begin
      s4_d.status          = s3_q.status;
      s4_d.freq_low        = sat_freq(sl);
      s4_d.freq_high       = sat_freq(sh);
      s4_d.first_low_bin   = s3_q.b0;
      s4_d.first_high_bin  = s3_q.b1;
      s4_d.second_low_bin  = s3_q.b2;
      s4_d.second_high_bin = s3_q.b3;
    end else begin
      s4_d                 = '0;
      s4_d.status          = bbrc_pkg::STAT_OUT;
    end
  end

  always_comb begin
    en[3] = !vld_q[3] || out_ready_i;
    en[2] = !vld_q[2] || en[3];
    en[1] = !vld_q[1] || en[2];
    en[0] = !vld_q[0] || en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
    if (en[1]) s2_q <= s2_d;
    if (en[2]) s3_q <= s3_d;
    if (en[3]) s4_q <= s4_d;
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[3];
  assign out_data_o  = s4_q;

endmodule
